// ----- rtl/icb_pkg.sv -----
// Shared definitions for the insertable character buffer.
// Holds command and status codes, field widths and the result record.
// No dependencies.
`default_nettype none

package icb_pkg;

    // Default store depth in bytes.
    localparam int DEPTH_DEF = 256;

    // Field widths of the transaction payloads.
    localparam int CMD_W     = 2;
    localparam int POS_W     = 16;
    localparam int CHAR_W    = 8;
    localparam int STAT_W    = 2;
    localparam int LEN_OUT_W = 9;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // One result record handed from the sequencer to the output stage.
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CHAR_W-1:0]    char_out;
        logic [LEN_OUT_W-1:0] length_out;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/icb_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No package dependencies.
`default_nettype none

module icb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/icb_ctrl.sv -----
// Command sequencer of the insertable character buffer: length register,
// shift loop over the text RAM and result formation. Depends on icb_pkg.
`default_nettype none

module icb_ctrl
    import icb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Command side.
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CMD_W-1:0]         cmd,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic [CHAR_W-1:0]        char_in,
    // Text RAM side.
    output logic                          mem_wr_en,
    output logic      [$clog2(DEPTH)-1:0] mem_wr_addr,
    output logic      [CHAR_W-1:0]        mem_wr_data,
    output logic                          mem_rd_en,
    output logic      [$clog2(DEPTH)-1:0] mem_rd_addr,
    input  wire logic [CHAR_W-1:0]        mem_rd_data,
    // Result side.
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output res_t                          res
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = POS_W + 1;

    localparam logic [LW-1:0] LEN_FULL = LW'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_DEL     = 3'd3;
    localparam logic [2:0] S_DEL_FIN = 3'd4;
    localparam logic [2:0] S_RD_WAIT = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     put_reg, put_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              wpend_reg, wpend_next;
    logic [AW-1:0]     waddr_reg, waddr_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0] byte_reg, byte_next;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic          pos_past;
    logic          pos_beyond;
    logic [AW-1:0] pos_addr;
    logic [AW-1:0] last_addr;

    // Position compared against the current length.
    assign pos_ext    = CW'(position);
    assign len_ext    = CW'(len_reg);
    assign pos_past   = (pos_ext >= len_ext);
    assign pos_beyond = (pos_ext > len_ext);
    assign pos_addr   = AW'(position);
    assign last_addr  = AW'(len_reg - LW'(1));

    // Next-state and RAM port logic.
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        put_next    = put_reg;
        ch_next     = ch_reg;
        wpend_next  = 1'b0;
        waddr_next  = waddr_reg;
        status_next = status_reg;
        byte_next   = byte_reg;

        in_ready    = 1'b0;
        res_valid   = 1'b0;

        // A pending shift write lands in the cycle after its read.
        mem_wr_en   = wpend_reg;
        mem_wr_addr = waddr_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = ST_DONE;
                    byte_next   = '0;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (len_reg == LEN_FULL)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                put_next = pos_beyond ? AW'(len_reg) : pos_addr;
                                ch_next  = char_in;
                                if (pos_past)
                                begin
                                    // Append: nothing to move.
                                    state_next = S_INS_PUT;
                                end
                                else
                                begin
                                    cnt_next   = last_addr;
                                    state_next = S_INS;
                                end
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_past)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_EMIT;
                            end
                            else if (LW'(pos_addr) + LW'(1) == len_reg)
                            begin
                                // Last byte removed: nothing to move.
                                state_next = S_DEL_FIN;
                            end
                            else
                            begin
                                cnt_next   = pos_addr + AW'(1);
                                state_next = S_DEL;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            len_next   = '0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            if (pos_past)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = pos_addr;
                                state_next  = S_RD_WAIT;
                            end
                        end
                    endcase
                end
            end

            // Move bytes up, highest first; each read is written one entry higher.
            S_INS:
            begin
                mem_rd_en  = 1'b1;
                wpend_next = 1'b1;
                waddr_next = cnt_reg + AW'(1);
                if (cnt_reg == put_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg - AW'(1);
                end
            end

            // Let the last shift write finish, then place the new byte.
            S_INS_PUT:
            begin
                if (!wpend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = put_reg;
                    mem_wr_data = ch_reg;
                    len_next    = len_reg + LW'(1);
                    state_next  = S_EMIT;
                end
            end

            // Move bytes down, lowest first; each read is written one entry lower.
            S_DEL:
            begin
                mem_rd_en  = 1'b1;
                wpend_next = 1'b1;
                waddr_next = cnt_reg - AW'(1);
                if (cnt_reg == last_addr)
                begin
                    state_next = S_DEL_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            S_DEL_FIN:
            begin
                if (!wpend_reg)
                begin
                    len_next   = len_reg - LW'(1);
                    state_next = S_EMIT;
                end
            end

            S_RD_WAIT:
            begin
                byte_next  = mem_rd_data;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            wpend_reg <= wpend_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        put_reg    <= put_next;
        ch_reg     <= ch_next;
        waddr_reg  <= waddr_next;
        status_reg <= status_next;
        byte_reg   <= byte_next;
    end

    // Result record; the length is the one held after the command.
    always_comb
    begin
        res.status     = status_reg;
        res.char_out   = byte_reg;
        res.length_out = LEN_OUT_W'(len_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/insertable_char_buffer.sv -----
// Top level of the insertable character buffer: text RAM, command sequencer
// and output register. Depends on icb_pkg, icb_ram and icb_ctrl.
//
//   Channel   Handshake            Payload
//   command   in_valid / in_ready  cmd, position, char_in
//   result    out_valid/out_ready  status, char_out, length_out
//
// Clear, rejected and out-of-range commands go straight to the result; a read waits
// for the registered RAM data. Insert at p below length L shifts bytes p..L-1 up
// and, once the last one lands, writes the new byte; an append writes it at L.
// Delete at p shifts bytes p+1..L-1 down, or none for the last byte, then waits
// for the last write. Shifts move a byte per cycle via single RAM read/write ports.
// Reset empties the buffer at once; the RAM itself is not cleared.
// A waiting result sits in the output register while the next command is taken.
`default_nettype none

module insertable_char_buffer
    import icb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic [CHAR_W-1:0]    char_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [STAT_W-1:0]    status,
    output logic      [CHAR_W-1:0]    char_out,
    output logic      [LEN_OUT_W-1:0] length_out
);

    localparam int AW = $clog2(DEPTH);

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [CHAR_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [CHAR_W-1:0] mem_rd_data;

    logic res_valid;
    logic res_ready;
    res_t res;

    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    // Text store.
    icb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Command sequencer.
    icb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .position    (position),
        .char_in     (char_in),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: takes a result when empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign char_out   = out_reg.char_out;
    assign length_out = out_reg.length_out;

endmodule

`default_nettype wire
